[sv/ssg_pkg.sv]
// Package: payload types, codes and weight constants for the stencil gather block.
package ssg_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         kind;
    logic [11:0]        dst_index;
    logic [11:0]        index_a;
    logic [11:0]        index_b;
    logic [11:0]        index_c;
    logic [11:0]        index_d;
    logic [12:0]        ring_start;
    logic [3:0]         valence;
    logic [2:0]         component;
    logic signed [31:0] data;
    logic               item_last;
  } ssg_cmd_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [1:0]         status;
    logic               saturated;
    logic               batch_done;
  } ssg_rsp_t;

  // store sizes follow the 12-bit vertex and 13-bit ring fields of a command
  localparam int VERTEX_COUNT = 4096;
  localparam int RING_DEPTH   = 8192;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RING    = 2'd2;
  localparam logic [1:0] OP_STENCIL = 2'd3;

  localparam logic [2:0] KIND_AVG4  = 3'd0;
  localparam logic [2:0] KIND_FACE  = 3'd1;
  localparam logic [2:0] KIND_VA    = 3'd2;
  localparam logic [2:0] KIND_VB1   = 3'd3;
  localparam logic [2:0] KIND_VB2   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_VALENCE = 2'd1;
  localparam logic [1:0] ST_KIND    = 2'd2;

  localparam int WFRAC = 18;
  localparam logic [18:0] W_QUARTER   = 19'd65536;
  localparam logic [18:0] W_THIRD     = 19'd87381;
  localparam logic [18:0] W_THREE_Q   = 19'd196608;
  localparam logic [18:0] W_EIGHTH    = 19'd32768;
  localparam logic [18:0] W_HALF      = 19'd131072;
  localparam logic [18:0] W_SIXTEENTH = 19'd16384;

  // B2 center weight round((n-2)*2^18/n), n up to 16
  function automatic logic [18:0] b2_center(input logic [4:0] n);
    logic [18:0] w;
    case (n)
      5'd3:  w = 19'd87381;
      5'd4:  w = 19'd131072;
      5'd5:  w = 19'd157286;
      5'd6:  w = 19'd174763;
      5'd7:  w = 19'd187246;
      5'd8:  w = 19'd196608;
      5'd9:  w = 19'd203890;
      5'd10: w = 19'd209715;
      5'd11: w = 19'd214481;
      5'd12: w = 19'd218453;
      5'd13: w = 19'd221814;
      5'd14: w = 19'd224695;
      5'd15: w = 19'd227191;
      5'd16: w = 19'd229376;
      default: w = '0;
    endcase
    return w;
  endfunction

  // B2 ring weight round(2^18/n^2)
  function automatic logic [18:0] b2_ring(input logic [4:0] n);
    logic [18:0] w;
    case (n)
      5'd3:  w = 19'd29127;
      5'd4:  w = 19'd16384;
      5'd5:  w = 19'd10486;
      5'd6:  w = 19'd7282;
      5'd7:  w = 19'd5350;
      5'd8:  w = 19'd4096;
      5'd9:  w = 19'd3236;
      5'd10: w = 19'd2621;
      5'd11: w = 19'd2166;
      5'd12: w = 19'd1820;
      5'd13: w = 19'd1551;
      5'd14: w = 19'd1337;
      5'd15: w = 19'd1165;
      5'd16: w = 19'd1024;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[sv/ssg_ring_mem.sv]
// Module: ring index table, one write or one registered read per cycle.
module ssg_ring_mem #(
  parameter int RING_DEPTH = 8192
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(RING_DEPTH)-1:0] addr,
  input  logic [11:0]                   wdata,
  output logic [11:0]                   rdata
);

  logic [11:0] mem [RING_DEPTH];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/ssg_vtx_mem.sv]
// Module: vertex component store, one write or one registered read per cycle.
module ssg_vtx_mem #(
  parameter int DEPTH = 24576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [31:0]              wdata,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  // write or read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/ssg_mac.sv]
// Module: multiply-accumulate of one source component by one weight, with rounding.
module ssg_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] src,
  input  logic [18:0]        wt,
  output logic signed [31:0] q,
  output logic               sat
);

  logic signed [51:0] prod;
  logic signed [56:0] acc;
  logic signed [56:0] rnd;
  logic signed [38:0] sh;

  // register product, then accumulate
  always_ff @(posedge clk) begin
    prod <= src * $signed({1'b0, wt});
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + 57'(prod);
    end
  end

  // round half up and clamp
  always_comb begin
    rnd = acc + 57'sd131072;
    sh  = 39'(rnd >>> 18);
    sat = (sh > 39'sd2147483647) || (sh < -39'sd2147483648);
    if (sh > 39'sd2147483647) begin
      q = 32'sh7fffffff;
    end else if (sh < -39'sd2147483648) begin
      q = 32'sh80000000;
    end else begin
      q = 32'(sh);
    end
  end

endmodule

[sv/subdivision_stencil_gather.sv]
// Top level: stencil gather sequencer over the vertex store and ring table.
//
//  channel  | signals                  | handshake
//  command  | start, busy, cmd         | taken when start and not busy
//  result   | done, rsp                | one cycle strobe, no stall
//
// Access items hold busy through the access and response states; the result
// beat follows. A stencil of T terms first loads its ring indices (VB1 and
// VB2 only, one per ring term), then per component reads T sources and
// drains the MAC, then writes back one result per component. The single port
// of the vertex memory sets the rate.
// Reset clears the sequencer only; the memories hold no reset value.
module subdivision_stencil_gather
  import ssg_pkg::*;
#(
  parameter int COMPONENTS   = 6,
  parameter int MAX_VALENCE  = 10
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  ssg_cmd_t cmd,
  output logic     done,
  output ssg_rsp_t rsp
);

  localparam int VW   = $clog2(VERTEX_COUNT);
  localparam int CW   = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int DEP  = VERTEX_COUNT * COMPONENTS;
  localparam int AW   = $clog2(DEP);
  localparam int RW   = $clog2(RING_DEPTH);
  localparam int MT   = 2 * MAX_VALENCE + 1;
  localparam int TW   = $clog2(MT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_RING = 3'd2;
  localparam logic [2:0] S_GATH = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_RSP  = 3'd5;

  logic [2:0]  state;
  ssg_cmd_t    c;
  logic [VW-1:0] src [MT];
  logic [TW-1:0] terms, k, rk;
  logic [CW-1:0] comp;
  logic [2:0]    phase;
  logic [18:0]   w_a, w_r;
  logic          face3, sat_any;
  logic signed [31:0] res [COMPONENTS];

  // memory ports
  logic          v_we, r_we;
  logic [AW-1:0] v_addr;
  logic [RW-1:0] r_addr;
  logic [31:0]   v_wdata, v_rdata;
  logic [11:0]   r_rdata;

  ssg_vtx_mem #(.DEPTH(DEP)) u_vtx (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );
  ssg_ring_mem #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(c.index_a), .rdata(r_rdata)
  );

  // weight of term k for the current kind
  logic [18:0] wt_k;
  always_comb begin
    if (k == '0) begin
      wt_k = w_a;
    end else if (c.kind == KIND_FACE && face3 && k == TW'(3)) begin
      wt_k = '0;
    end else if (k >= TW'(1) && (c.kind == KIND_VB1 || c.kind == KIND_VB2 ||
                 c.kind == KIND_AVG4 || c.kind == KIND_FACE)) begin
      wt_k = w_r;
    end else begin
      wt_k = W_EIGHTH;
    end
  end

  // MAC: the read data and then its product are registered before the product accumulates
  logic        mac_clr, en_p1, en_p2;
  logic [18:0] wt_p1;
  logic signed [31:0] mq;
  logic        msat;
  ssg_mac u_mac (
    .clk(clk), .clr(mac_clr), .en(en_p2), .src(v_rdata),
    .wt(wt_p1), .q(mq), .sat(msat)
  );

  logic [VW-1:0] cur_src;
  assign cur_src = src[k];
  assign v_addr = (state == S_WB)
    ? AW'(c.dst_index[VW-1:0]) * AW'(COMPONENTS) + AW'(comp)
    : (state == S_GATH)
      ? AW'(cur_src) * AW'(COMPONENTS) + AW'(comp)
      : AW'(c.index_a[VW-1:0]) * AW'(COMPONENTS) + AW'(c.component);
  assign v_wdata = (state == S_WB) ? res[comp] : c.data;
  assign v_we = ((state == S_ACC) && phase == 3'd0 && c.op == OP_WRITE &&
                 32'(c.component) < COMPONENTS) || (state == S_WB);
  assign r_addr = RW'(c.ring_start + 13'(rk));
  assign r_we = (state == S_ACC) && phase == 3'd0 && c.op == OP_RING;
  assign busy = (state != S_IDLE);

  logic [4:0] n5;
  assign n5 = {1'b0, cmd.valence};

  // sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    wt_p1 <= wt_k;
    en_p1 <= 1'b0;
    en_p2 <= en_p1;
    mac_clr <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            c <= cmd;
            phase <= '0;
            k <= '0;
            rk <= '0;
            comp <= '0;
            sat_any <= 1'b0;
            mac_clr <= 1'b1;
            rsp <= '0;
            face3 <= (cmd.index_c == cmd.index_d);
            src[0] <= cmd.index_a[VW-1:0];
            src[1] <= cmd.index_b[VW-1:0];
            src[2] <= cmd.index_c[VW-1:0];
            src[3] <= cmd.index_d[VW-1:0];
            if (cmd.op != OP_STENCIL) begin
              state <= S_ACC;
            end else begin
              rsp.batch_done <= cmd.item_last;
              case (cmd.kind)
                KIND_AVG4, KIND_FACE: begin
                  terms <= TW'(4);
                  w_a <= (cmd.kind == KIND_FACE && cmd.index_c == cmd.index_d)
                         ? W_THIRD : W_QUARTER;
                  w_r <= (cmd.kind == KIND_FACE && cmd.index_c == cmd.index_d)
                         ? W_THIRD : W_QUARTER;
                  state <= S_GATH;
                end
                KIND_VA: begin
                  terms <= TW'(3);
                  w_a <= W_THREE_Q;
                  w_r <= W_EIGHTH;
                  state <= S_GATH;
                end
                KIND_VB1: begin
                  terms <= TW'(9);
                  w_a <= W_HALF;
                  w_r <= W_SIXTEENTH;
                  state <= S_RING;
                end
                KIND_VB2: begin
                  if (cmd.valence < 4'd3 || 32'(cmd.valence) > MAX_VALENCE) begin
                    rsp.status <= ST_VALENCE;
                    state <= S_RSP;
                  end else begin
                    terms <= TW'(2 * n5 + 5'd1);
                    w_a <= b2_center(n5);
                    w_r <= b2_ring(n5);
                    state <= S_RING;
                  end
                end
                default: begin
                  rsp.status <= ST_KIND;
                  state <= S_RSP;
                end
              endcase
            end
          end
        end
        // access: issue, then capture
        S_ACC: begin
          phase <= phase + 3'd1;
          if (phase == 3'd1) begin
            if (c.op == OP_READ && 32'(c.component) < COMPONENTS) begin
              rsp.read_data <= v_rdata;
            end
            state <= S_RSP;
          end
        end
        // load ring indices, an address phase then a capture phase each
        S_RING: begin
          if (phase == 3'd0) begin
            phase <= 3'd1;
          end else begin
            src[rk + TW'(1)] <= r_rdata[VW-1:0];
            phase <= 3'd0;
            rk <= rk + TW'(1);
            if (rk + TW'(2) == terms) begin
              state <= S_GATH;
              k <= '0;
            end
          end
        end
        // stream sources, then drain the MAC
        S_GATH: begin
          if (phase == 3'd0) begin
            en_p1 <= 1'b1;
            if (k + TW'(1) == terms) begin
              phase <= 3'd1;
            end else begin
              k <= k + TW'(1);
            end
          end else if (phase == 3'd4) begin
            res[comp] <= mq;
            sat_any <= sat_any | msat;
            mac_clr <= 1'b1;
            phase <= '0;
            k <= '0;
            if (32'(comp) == COMPONENTS - 1) begin
              comp <= '0;
              state <= S_WB;
            end else begin
              comp <= comp + CW'(1);
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        // write back all components
        S_WB: begin
          if (32'(comp) == COMPONENTS - 1) begin
            rsp.saturated <= sat_any;
            state <= S_RSP;
          end else begin
            comp <= comp + CW'(1);
          end
        end
        S_RSP: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[test/tb.sv]
// Testbench for subdivision_stencil_gather: priming writes, directed rows, then random command traffic.
module tb
  import ssg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVERT    = 4096;
  localparam int NCOMP    = 6;
  localparam int NRING    = 8192;
  localparam int IDLE_CAP = 4000;
  localparam int NRANDOM  = 920;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  ssg_cmd_t cmd;
  logic     done;
  ssg_rsp_t rsp;

  subdivision_stencil_gather DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .rsp(rsp)
  );

  // Shadow copy of the vertex store and ring table
  logic signed [31:0] vert_mem [NVERT][NCOMP];
  logic [11:0]        ring_mem [NRING];
  bit                 comp_set [NVERT][NCOMP];
  bit                 vert_full [NVERT];
  bit                 ring_set [NRING];
  int                 full_verts[$];
  int                 ring_addrs[$];

  ssg_rsp_t  rsp_q[$];
  bit        cur_fixed;
  ssg_rsp_t  cur_rsp;
  int        n_taken, n_checked, n_fail, idle_cnt;
  int        n_stencil, n_sat, n_reject;
  bit        burst;

  typedef struct {
    ssg_cmd_t c;
    bit       fixed;
    ssg_rsp_t r;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void note_comp(int v, int k);
    bit all;
    comp_set[v][k] = 1'b1;
    all = 1'b1;
    for (int i = 0; i < NCOMP; i++) all &= comp_set[v][i];
    if (all && !vert_full[v]) begin
      vert_full[v] = 1'b1;
      full_verts.push_back(v);
    end
  endfunction

  // Execute one command on the shadow state and return the answer it gives
  function automatic ssg_rsp_t apply_cmd(ssg_cmd_t c);
    ssg_rsp_t    r;
    int          src[21];
    longint      wt[21];
    int          nt;
    int          n;
    longint      one;
    longint      acc;
    longint      q;
    logic [31:0] res[NCOMP];
    r = '0;
    one = longint'(1) << 18;
    nt = 0;
    case (c.op)
      OP_WRITE: begin
        if (c.component < NCOMP) begin
          vert_mem[c.index_a][c.component] = c.data;
          note_comp(int'(c.index_a), int'(c.component));
        end
        return r;
      end
      OP_READ: begin
        if (c.component < NCOMP) r.read_data = vert_mem[c.index_a][c.component];
        return r;
      end
      OP_RING: begin
        ring_mem[c.ring_start] = c.index_a;
        if (!ring_set[c.ring_start]) begin
          ring_set[c.ring_start] = 1'b1;
          ring_addrs.push_back(int'(c.ring_start));
        end
        return r;
      end
      default: ;
    endcase
    r.batch_done = c.item_last;
    src[0] = int'(c.index_a); src[1] = int'(c.index_b);
    src[2] = int'(c.index_c); src[3] = int'(c.index_d);
    case (c.kind)
      KIND_AVG4: begin
        for (int i = 0; i < 4; i++) wt[i] = 65536;
        nt = 4;
      end
      KIND_FACE: begin
        // triangle when the last two corners coincide
        if (c.index_c == c.index_d) begin
          for (int i = 0; i < 3; i++) wt[i] = 87381;
          wt[3] = 0;
        end else begin
          for (int i = 0; i < 4; i++) wt[i] = 65536;
        end
        nt = 4;
      end
      KIND_VA: begin
        wt[0] = 196608; wt[1] = 32768; wt[2] = 32768;
        nt = 3;
      end
      KIND_VB1: begin
        wt[0] = 131072;
        for (int j = 0; j < 8; j++) begin
          src[1 + j] = int'(ring_mem[(int'(c.ring_start) + j) % NRING]);
          wt[1 + j] = 16384;
        end
        nt = 9;
      end
      KIND_VB2: begin
        n = int'(c.valence);
        if (n < 3 || n > 10) begin
          r.status = ST_VALENCE;
          return r;
        end
        wt[0] = (2 * (n - 2) * one + n) / (2 * n);
        for (int j = 0; j < 2 * n; j++) begin
          src[1 + j] = int'(ring_mem[(int'(c.ring_start) + j) % NRING]);
          wt[1 + j] = (2 * one + n * n) / (2 * n * n);
        end
        nt = 1 + 2 * n;
      end
      default: begin
        r.status = ST_KIND;
        return r;
      end
    endcase
    // Gather all components before the destination is touched
    for (int k = 0; k < NCOMP; k++) begin
      acc = 0;
      for (int t = 0; t < nt; t++) acc += longint'(vert_mem[src[t]][k]) * wt[t];
      q = (acc + (longint'(1) << 17)) >>> 18;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647; r.saturated = 1'b1;
      end
      if (q < -64'sd2147483648) begin
        q = -64'sd2147483648; r.saturated = 1'b1;
      end
      res[k] = q[31:0];
    end
    for (int k = 0; k < NCOMP; k++) begin
      vert_mem[c.dst_index][k] = res[k];
      note_comp(int'(c.dst_index), k);
    end
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0h want %0h", n_checked, field, got, want);
    n_fail++;
  endtask

  // Take command beats and predict their answers
  always @(posedge clk) begin
    ssg_rsp_t p;
    if (!rst && start && !busy) begin
      p = apply_cmd(cmd);
      rsp_q.push_back(cur_fixed ? cur_rsp : p);
      if (cmd.op == OP_STENCIL) begin
        n_stencil++;
        if (p.saturated) n_sat++;
        if (p.status != ST_OK) n_reject++;
      end
      n_taken++;
    end
  end

  // Check result beats against the oldest expectation
  always @(posedge clk) begin
    ssg_rsp_t e;
    if (!rst && done) begin
      if (rsp_q.size() == 0) begin
        $display("unexpected result beat %0d", n_checked);
        n_fail++;
      end else begin
        e = rsp_q.pop_front();
        if (rsp.read_data !== e.read_data) report("read_data", rsp.read_data, e.read_data);
        if (rsp.status !== e.status) report("status", rsp.status, e.status);
        if (rsp.saturated !== e.saturated) report("saturated", rsp.saturated, e.saturated);
        if (rsp.batch_done !== e.batch_done) report("batch_done", rsp.batch_done, e.batch_done);
      end
      n_checked++;
    end
  end

  // Stop on a stall with no progress
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_CAP) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic ssg_cmd_t mk(logic [1:0] op, logic [2:0] kind, int dst, int a, int b,
                                  int c, int d, int rs, int n, int comp,
                                  logic [31:0] data, bit last);
    ssg_cmd_t x;
    x.op = op; x.kind = kind; x.dst_index = 12'(dst); x.index_a = 12'(a);
    x.index_b = 12'(b); x.index_c = 12'(c); x.index_d = 12'(d);
    x.ring_start = 13'(rs); x.valence = 4'(n);
    x.component = 3'(comp); x.data = data; x.item_last = last;
    return x;
  endfunction

  function automatic ssg_rsp_t ans(logic [31:0] rd, logic [1:0] st, bit last);
    ssg_rsp_t r;
    r.read_data = rd; r.status = st; r.saturated = 1'b0; r.batch_done = last;
    return r;
  endfunction

  function automatic void add_row(ssg_cmd_t c, bit fixed = 1'b0, ssg_rsp_t r = '0);
    row_t w;
    w.c = c; w.fixed = fixed; w.r = r;
    rows.push_back(w);
  endfunction

  // Drive one command beat after a random gap (none in a burst) and hold it until taken
  task automatic send(ssg_cmd_t c, bit fixed = 1'b0, ssg_rsp_t r = '0);
    int gap;
    int seen;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = c; cur_fixed = fixed; cur_rsp = r; start = 1'b1;
    seen = n_taken;
    do @(negedge clk); while (n_taken == seen);
  endtask

  function automatic int any_vert();
    return full_verts[$urandom_range(0, full_verts.size() - 1)];
  endfunction

  // Find a ring run whose entries are all written, or fall back to 0 after eight tries
  function automatic int ring_run(int len);
    int rs;
    bit ok;
    for (int tries = 0; tries < 8; tries++) begin
      rs = ring_addrs[$urandom_range(0, ring_addrs.size() - 1)];
      ok = 1'b1;
      for (int j = 0; j < len; j++) ok &= ring_set[(rs + j) % NRING];
      if (ok) return rs;
    end
    return 0;
  endfunction

  function automatic logic [31:0] any_data();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic ssg_cmd_t random_cmd();
    ssg_cmd_t     c;
    logic [127:0] raw;
    int sel;
    int len;
    raw = {$urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(ssg_cmd_t)-1:0];
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      c.op = OP_WRITE;
      c.component = 3'($urandom_range(0, 7));
      c.data = any_data();
    end else if (sel < 45) begin
      c.op = OP_READ;
      c.component = 3'($urandom_range(0, 7));
      if (c.component < NCOMP && !comp_set[c.index_a][c.component])
        c.index_a = 12'(any_vert());
    end else if (sel < 55) begin
      c.op = OP_RING;
      c.index_a = 12'(any_vert());
    end else begin
      c.op = OP_STENCIL;
      c.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      c.index_a = 12'(any_vert()); c.index_b = 12'(any_vert());
      c.index_c = 12'(any_vert()); c.index_d = 12'(any_vert());
      if (c.kind == KIND_FACE && $urandom_range(0, 2) == 0) c.index_d = c.index_c;
      if ($urandom_range(0, 4) != 0) c.valence = 4'($urandom_range(3, 10));
      len = (c.kind == KIND_VB1) ? 8 : 2 * int'(c.valence);
      if (c.kind == KIND_VB1 || (c.kind == KIND_VB2 && c.valence >= 3 && c.valence <= 10))
        c.ring_start = 13'(ring_run(len));
    end
    return c;
  endfunction

  initial begin
    int priming[8];
    logic [31:0] v;
    start = 1'b0; cmd = '0; rst = 1'b1; cur_fixed = 1'b0; cur_rsp = '0; burst = 1'b0;
    n_taken = 0; n_checked = 0; n_fail = 0; idle_cnt = 0;
    n_stencil = 0; n_sat = 0; n_reject = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Prime a few vertices, the two extremes included, and some ring runs
    priming = '{0, 1, 2, 3, 4095, 4094, 2730, 1365};
    foreach (priming[i])
      for (int k = 0; k < NCOMP; k++) begin
        v = (priming[i] == 4095) ? 32'h7FFF_FFFF :
            (priming[i] == 4094) ? 32'h8000_0000 : $urandom;
        send(mk(OP_WRITE, KIND_AVG4, 0, priming[i], 0, 0, 0, 0, 0, k, v, 0));
      end
    for (int j = 0; j < 24; j++)
      send(mk(OP_RING, KIND_AVG4, 0, priming[j % 8], 0, 0, 0, j, 0, 0, 0, 0));
    for (int j = 8184; j < 8191; j++)
      send(mk(OP_RING, KIND_AVG4, 0, priming[j % 8], 0, 0, 0, j, 0, 0, 0, 0));
    for (int j = 100; j < 120; j++)
      send(mk(OP_RING, KIND_AVG4, 0, (j < 110) ? 4095 : 4094, 0, 0, 0, j, 0, 0, 0, 0));

    // Directed rows: extremes, every op and kind, corner cases
    add_row(mk(OP_WRITE, KIND_AVG4, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0), 1, ans(0, ST_OK, 0));
    add_row(mk(OP_READ, KIND_AVG4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            ans(32'h8000_0000, ST_OK, 0));
    add_row(mk(OP_WRITE, KIND_AVG4, 0, 1, 0, 0, 0, 0, 0, 7, 32'hFFFF_FFFF, 1), 1,
            ans(0, ST_OK, 0));
    add_row(mk(OP_READ, KIND_AVG4, 0, 1, 0, 0, 0, 0, 0, 6, 0, 0), 1, ans(0, ST_OK, 0));
    add_row(mk(OP_READ, KIND_AVG4, 0, 4095, 0, 0, 0, 0, 0, 5, 0, 0), 1,
            ans(32'h7FFF_FFFF, ST_OK, 0));
    add_row(mk(OP_RING, KIND_AVG4, 0, 4095, 0, 0, 0, 8191, 0, 0, 0, 0), 1, ans(0, ST_OK, 0));
    add_row(mk(OP_STENCIL, KIND_AVG4, 5, 0, 1, 2, 3, 0, 0, 0, 0, 0));
    add_row(mk(OP_STENCIL, KIND_FACE, 6, 4095, 2730, 1365, 2, 0, 0, 0, 0, 1));
    add_row(mk(OP_STENCIL, KIND_FACE, 7, 4095, 4095, 4095, 4095, 0, 0, 0, 0, 0));
    add_row(mk(OP_STENCIL, KIND_VA, 8, 4095, 4094, 2730, 0, 0, 0, 0, 0, 1));
    add_row(mk(OP_STENCIL, KIND_VB1, 9, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_STENCIL, KIND_VB1, 10, 2, 0, 0, 0, 8188, 0, 0, 0, 1));
    add_row(mk(OP_STENCIL, KIND_VB2, 11, 3, 0, 0, 0, 8184, 3, 0, 0, 0));
    add_row(mk(OP_STENCIL, KIND_VB2, 12, 1365, 0, 0, 0, 0, 10, 0, 0, 1));
    // ring weights round up past unity, so full-scale sources clamp both ways
    add_row(mk(OP_STENCIL, KIND_VB2, 2, 4095, 0, 0, 0, 100, 5, 0, 0, 0));
    add_row(mk(OP_STENCIL, KIND_VB2, 3, 4094, 0, 0, 0, 110, 5, 0, 0, 1));
    add_row(mk(OP_STENCIL, KIND_VB2, 13, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
            ans(0, ST_VALENCE, 1));
    add_row(mk(OP_STENCIL, KIND_VB2, 13, 0, 0, 0, 0, 0, 2, 0, 0, 0), 1,
            ans(0, ST_VALENCE, 0));
    add_row(mk(OP_STENCIL, KIND_VB2, 13, 0, 0, 0, 0, 0, 11, 0, 0, 1), 1,
            ans(0, ST_VALENCE, 1));
    add_row(mk(OP_STENCIL, KIND_VB2, 13, 0, 0, 0, 0, 0, 15, 0, 0, 0), 1,
            ans(0, ST_VALENCE, 0));
    add_row(mk(OP_STENCIL, 3'd5, 13, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, ans(0, ST_KIND, 1));
    add_row(mk(OP_STENCIL, 3'd6, 13, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ans(0, ST_KIND, 0));
    add_row(mk(OP_STENCIL, 3'd7, 4095, 0, 0, 0, 0, 8191, 15, 7, 32'hFFFF_FFFF, 1), 1,
            ans(0, ST_KIND, 1));
    // destination equal to a source reads the old value
    add_row(mk(OP_STENCIL, KIND_AVG4, 1, 1, 2, 3, 0, 0, 0, 0, 0, 0));
    foreach (rows[i]) send(rows[i].c, rows[i].fixed, rows[i].r);

    // Random traffic, in stretches that are gapped or, at random, back-to-back
    for (int i = 0; i < NRANDOM; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      send(random_cmd());
    end
    start = 1'b0;

    while (rsp_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("covered %0d commands, %0d stencils (%0d clamped, %0d rejected)",
             n_taken, n_stencil, n_sat, n_reject);
    $display("checked %0d results, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0 && rsp_q.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

[files.f]
sv/ssg_pkg.sv
sv/ssg_ring_mem.sv
sv/ssg_vtx_mem.sv
sv/ssg_mac.sv
sv/subdivision_stencil_gather.sv
test/tb.sv
